// ===== rtl/mmbb_pkg.sv =====
`timescale 1ns / 1ps

package mmbb_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int POS_W   = 10;
    localparam int SIZE_W  = 11;
    localparam int PIX_W   = 8;
    localparam int DEV_W   = 8;
    localparam int TALLY_W = 19;
    localparam int VSUM_W  = 28;
    localparam int SSUM_W  = 37;
    localparam int CNT_W   = 21;
    localparam int MUL_W   = 28;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int GATE_W  = 59;
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_W   = 80;

    localparam logic [PIX_W-1:0]  CHANGE_VALUE = 8'd255;
    localparam logic [SIZE_W-1:0] PAD          = 11'd10;

    localparam logic [SIZE_W-1:0] WIDTH_MAX  = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] HEIGHT_MAX = SIZE_W'(MAX_HEIGHT);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH   = 3'd0,
        REG_FRAME_HEIGHT  = 3'd1,
        REG_WIN_X_BEGIN   = 3'd2,
        REG_WIN_X_END     = 3'd3,
        REG_WIN_Y_BEGIN   = 3'd4,
        REG_WIN_Y_END     = 3'd5,
        REG_MAX_DEVIATION = 3'd6
    } t_cfg_reg;

    typedef enum logic [2:0] {
        MOP_NONE   = 3'd0,
        MOP_DD     = 3'd1,
        MOP_NN     = 3'd2,
        MOP_LHS_LO = 3'd3,
        MOP_LHS_HI = 3'd4,
        MOP_VV     = 3'd5,
        MOP_RHS_LO = 3'd6,
        MOP_RHS_HI = 3'd7
    } t_mul_op;

    typedef struct packed {
        logic    pix_en;
        logic    frame_done;
        t_mul_op mul_op;
        logic    cmp_en;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// ===== rtl/motion_mask_bounding_box.sv =====
`timescale 1ns / 1ps

// Motion-mask bounding box. Mask pixels stream in raster order, one per transfer, with
// tlast on the last pixel of a frame; column and row are tracked internally from the
// configured frame size. Inside the search window every second column and row is sampled
// and pixels equal to 255 widen a bounding box. After the tlast pixel the block stops
// taking pixels while a single shared 28x28 multiplier forms the seven
// partial products of the deviation test (N*S2 - S1^2 < D^2*N^2), and while the previous
// result is still waiting on the output. One result per frame then appears: the padded
// box, its centre and the change count, or all zeros when the test fails or no change
// was seen. During a frame pixels are accepted at one per clock. Configuration writes
// take effect at once and belong between frames.

module motion_mask_bounding_box
    import mmbb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // mask_pixel
    input  logic                 s_axis_tlast,   // frame_end
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // motion_found, center_x, center_y, box_left, box_top, box_right, box_bottom,
    // changed_count
    output logic [OUT_W-1:0]     m_axis_tdata
);

    t_dp_cmd    cmd;
    t_dp_status status;

    mmbb_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    mmbb_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pixel     (s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ===== rtl/mmbb_ctrl.sv =====
`timescale 1ns / 1ps

module mmbb_ctrl
    import mmbb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tlast,
    output logic       s_axis_tready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [10:0] {
        S_ACCUM  = 11'b000_0000_0001,
        S_DD     = 11'b000_0000_0010,
        S_NN     = 11'b000_0000_0100,
        S_LHS_LO = 11'b000_0000_1000,
        S_LHS_HI = 11'b000_0001_0000,
        S_VV     = 11'b000_0010_0000,
        S_RHS_LO = 11'b000_0100_0000,
        S_RHS_HI = 11'b000_1000_0000,
        S_DRAIN  = 11'b001_0000_0000,
        S_CMP    = 11'b010_0000_0000,
        S_LOAD   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign s_axis_tready = (r_state == S_ACCUM);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state           = r_state;
        o_cmd.pix_en      = 1'b0;
        o_cmd.frame_done  = 1'b0;
        o_cmd.mul_op      = MOP_NONE;
        o_cmd.cmp_en      = 1'b0;
        o_cmd.load_out    = 1'b0;
        unique case (r_state)
            S_ACCUM: begin
                o_cmd.pix_en     = accept;
                o_cmd.frame_done = accept && s_axis_tlast;
                if (accept && s_axis_tlast) begin
                    n_state = S_DD;
                end
            end
            S_DD: begin
                o_cmd.mul_op = MOP_DD;
                n_state      = S_NN;
            end
            S_NN: begin
                o_cmd.mul_op = MOP_NN;
                n_state      = S_LHS_LO;
            end
            S_LHS_LO: begin
                o_cmd.mul_op = MOP_LHS_LO;
                n_state      = S_LHS_HI;
            end
            S_LHS_HI: begin
                o_cmd.mul_op = MOP_LHS_HI;
                n_state      = S_VV;
            end
            S_VV: begin
                o_cmd.mul_op = MOP_VV;
                n_state      = S_RHS_LO;
            end
            S_RHS_LO: begin
                o_cmd.mul_op = MOP_RHS_LO;
                n_state      = S_RHS_HI;
            end
            S_RHS_HI: begin
                o_cmd.mul_op = MOP_RHS_HI;
                n_state      = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp_en = 1'b1;
                n_state      = S_LOAD;
            end
            S_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_ACCUM;
                end
            end
            default: begin
                n_state = S_ACCUM;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCUM;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/mmbb_datapath.sv =====
`timescale 1ns / 1ps

module mmbb_datapath
    import mmbb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [PIX_W-1:0]     i_pixel,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [OUT_W-1:0]     o_out_data
);

    // configuration
    logic [SIZE_W-1:0] r_frame_width, r_frame_height;
    logic [POS_W-1:0]  r_x_begin, r_y_begin;
    logic [SIZE_W-1:0] r_x_end, r_y_end;
    logic [DEV_W-1:0]  r_max_dev;

    // frame accumulators
    logic [POS_W-1:0]   r_col, r_row, n_col, n_row;
    logic [TALLY_W-1:0] r_tally, n_tally;
    logic [SIZE_W-1:0]  r_least_col, n_least_col, r_least_row, n_least_row;
    logic [POS_W-1:0]   r_great_col, n_great_col, r_great_row, n_great_row;
    logic [VSUM_W-1:0]  r_vsum, n_vsum;
    logic [SSUM_W-1:0]  r_ssum, n_ssum;
    logic [CNT_W-1:0]   r_count, n_count;

    // frame snapshot
    logic [TALLY_W-1:0] r_snap_tally;
    logic [SIZE_W-1:0]  r_snap_lc, r_snap_lr;
    logic [POS_W-1:0]   r_snap_gc, r_snap_gr;
    logic [VSUM_W-1:0]  r_snap_vsum;
    logic [SSUM_W-1:0]  r_snap_ssum;
    logic [CNT_W-1:0]   r_snap_count;

    // gate arithmetic
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] r_prod;
    t_mul_op           r_prod_op;
    logic [2*DEV_W-1:0] r_dd;
    logic [2*CNT_W-1:0] r_nn;
    logic [GATE_W-1:0] r_lhs, r_rhs;
    logic              r_gate;

    // box
    logic [SIZE_W-1:0] r_box_l, r_box_t, r_box_r, r_box_b;
    logic [SIZE_W-1:0] box_l, box_t, box_r, box_b;
    logic [SIZE_W-1:0] diff_x, diff_y, cen_x, cen_y;

    logic [SIZE_W-1:0]  w_eff, h_eff, col_inc, row_inc;
    logic [2*PIX_W-1:0] pix_sq;
    logic               sample;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;

    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = SIZE_W'(1);
        end else if (r_frame_width > WIDTH_MAX) begin
            w_eff = WIDTH_MAX;
        end else begin
            w_eff = r_frame_width;
        end
        if (r_frame_height == '0) begin
            h_eff = SIZE_W'(1);
        end else if (r_frame_height > HEIGHT_MAX) begin
            h_eff = HEIGHT_MAX;
        end else begin
            h_eff = r_frame_height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 11'd640;
            r_frame_height <= 11'd480;
            r_x_begin      <= 10'd0;
            r_x_end        <= 11'd640;
            r_y_begin      <= 10'd0;
            r_y_end        <= 11'd480;
            r_max_dev      <= 8'd100;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:   r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT:  r_frame_height <= i_cfg_data;
                REG_WIN_X_BEGIN:   r_x_begin      <= i_cfg_data[POS_W-1:0];
                REG_WIN_X_END:     r_x_end        <= i_cfg_data;
                REG_WIN_Y_BEGIN:   r_y_begin      <= i_cfg_data[POS_W-1:0];
                REG_WIN_Y_END:     r_y_end        <= i_cfg_data;
                REG_MAX_DEVIATION: r_max_dev      <= i_cfg_data[DEV_W-1:0];
                default: ;
            endcase
        end
    end

    // per pixel update
    assign pix_sq = i_pixel * i_pixel;
    assign sample = (r_col >= r_x_begin) && ({1'b0, r_col} < r_x_end) &&
                    (r_row >= r_y_begin) && ({1'b0, r_row} < r_y_end) &&
                    (r_col[0] == r_x_begin[0]) && (r_row[0] == r_y_begin[0]) &&
                    (i_pixel == CHANGE_VALUE);
    assign col_inc = {1'b0, r_col} + SIZE_W'(1);
    assign row_inc = {1'b0, r_row} + SIZE_W'(1);

    always_comb begin
        n_vsum      = r_vsum + VSUM_W'(i_pixel);
        n_ssum      = r_ssum + SSUM_W'(pix_sq);
        n_count     = r_count + CNT_W'(1);
        n_tally     = r_tally;
        n_least_col = r_least_col;
        n_great_col = r_great_col;
        n_least_row = r_least_row;
        n_great_row = r_great_row;
        if (sample) begin
            n_tally = r_tally + TALLY_W'(1);
            if (r_least_col > {1'b0, r_col}) n_least_col = {1'b0, r_col};
            if (r_great_col < r_col)         n_great_col = r_col;
            if (r_least_row > {1'b0, r_row}) n_least_row = {1'b0, r_row};
            if (r_great_row < r_row)         n_great_row = r_row;
        end
        n_row = r_row;
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (row_inc >= h_eff) ? '0 : row_inc[POS_W-1:0];
        end else begin
            n_col = col_inc[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.frame_done) begin
            r_col       <= '0;
            r_row       <= '0;
            r_tally     <= '0;
            r_least_col <= w_eff;
            r_great_col <= '0;
            r_least_row <= h_eff;
            r_great_row <= '0;
            r_vsum      <= '0;
            r_ssum      <= '0;
            r_count     <= '0;
        end else if (i_cmd.pix_en) begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_tally     <= n_tally;
            r_least_col <= n_least_col;
            r_great_col <= n_great_col;
            r_least_row <= n_least_row;
            r_great_row <= n_great_row;
            r_vsum      <= n_vsum;
            r_ssum      <= n_ssum;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_done) begin
            r_snap_tally <= n_tally;
            r_snap_lc    <= n_least_col;
            r_snap_gc    <= n_great_col;
            r_snap_lr    <= n_least_row;
            r_snap_gr    <= n_great_row;
            r_snap_vsum  <= n_vsum;
            r_snap_ssum  <= n_ssum;
            r_snap_count <= n_count;
        end
    end

    // shared multiplier, product registered and accumulated in the following cycle
    always_comb begin
        unique case (i_cmd.mul_op)
            MOP_NONE: begin
                mul_a = '0;
                mul_b = '0;
            end
            MOP_DD: begin
                mul_a = MUL_W'(r_max_dev);
                mul_b = MUL_W'(r_max_dev);
            end
            MOP_NN: begin
                mul_a = MUL_W'(r_snap_count);
                mul_b = MUL_W'(r_snap_count);
            end
            MOP_LHS_LO: begin
                mul_a = MUL_W'(r_snap_count);
                mul_b = MUL_W'(r_snap_ssum[18:0]);
            end
            MOP_LHS_HI: begin
                mul_a = MUL_W'(r_snap_count);
                mul_b = MUL_W'(r_snap_ssum[SSUM_W-1:19]);
            end
            MOP_VV: begin
                mul_a = r_snap_vsum;
                mul_b = r_snap_vsum;
            end
            MOP_RHS_LO: begin
                mul_a = MUL_W'(r_dd);
                mul_b = MUL_W'(r_nn[CNT_W-1:0]);
            end
            MOP_RHS_HI: begin
                mul_a = MUL_W'(r_dd);
                mul_b = MUL_W'(r_nn[2*CNT_W-1:CNT_W]);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_prod_op <= MOP_NONE;
        end else begin
            r_prod_op <= i_cmd.mul_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_done) begin
            r_lhs <= '0;
            r_rhs <= '0;
        end else begin
            unique case (r_prod_op)
                MOP_NONE:   ;
                MOP_DD:     r_dd  <= r_prod[2*DEV_W-1:0];
                MOP_NN:     r_nn  <= r_prod[2*CNT_W-1:0];
                MOP_LHS_LO: r_lhs <= r_lhs + GATE_W'(r_prod);
                MOP_LHS_HI: r_lhs <= r_lhs + (GATE_W'(r_prod) << 19);
                MOP_VV:     r_rhs <= r_rhs + GATE_W'(r_prod);
                MOP_RHS_LO: r_rhs <= r_rhs + GATE_W'(r_prod);
                MOP_RHS_HI: r_rhs <= r_rhs + (GATE_W'(r_prod) << CNT_W);
            endcase
        end
        if (i_cmd.cmp_en) begin
            r_gate <= (r_lhs < r_rhs) && (r_snap_tally != '0);
        end
    end

    // padded box
    always_comb begin
        box_l = (r_snap_lc > PAD) ? r_snap_lc - PAD : r_snap_lc;
        box_t = (r_snap_lr > PAD) ? r_snap_lr - PAD : r_snap_lr;
        box_r = ((SIZE_W+1)'(r_snap_gc) + (SIZE_W+1)'(PAD) + (SIZE_W+1)'(1)
                 < (SIZE_W+1)'(w_eff)) ? SIZE_W'(r_snap_gc) + PAD : SIZE_W'(r_snap_gc);
        box_b = ((SIZE_W+1)'(r_snap_gr) + (SIZE_W+1)'(PAD) + (SIZE_W+1)'(1)
                 < (SIZE_W+1)'(h_eff)) ? SIZE_W'(r_snap_gr) + PAD : SIZE_W'(r_snap_gr);
    end

    always_ff @(posedge i_clk) begin
        r_box_l <= box_l;
        r_box_t <= box_t;
        r_box_r <= box_r;
        r_box_b <= box_b;
    end

    assign diff_x = r_box_r - r_box_l;
    assign diff_y = r_box_b - r_box_t;
    assign cen_x  = r_box_l + (diff_x >> 1);
    assign cen_y  = r_box_t + (diff_y >> 1);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_out) begin
            if (r_gate) begin
                r_out_data <= {r_snap_tally, r_box_b[POS_W-1:0], r_box_r[POS_W-1:0],
                               r_box_t[POS_W-1:0], r_box_l[POS_W-1:0],
                               cen_y[POS_W-1:0], cen_x[POS_W-1:0], 1'b1};
            end else begin
                r_out_data <= '0;
            end
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;

endmodule

// ===== tb/sv/tb_motion_mask_bounding_box.sv =====
`timescale 1ns / 1ps

module tb_motion_mask_bounding_box;
    import mmbb_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 20;
    localparam int LONG_HOLD     = 400;
    localparam int BOX_PAD       = int'(PAD);

    typedef struct packed {
        logic [TALLY_W-1:0] changed_count;
        logic [POS_W-1:0]   box_bottom;
        logic [POS_W-1:0]   box_right;
        logic [POS_W-1:0]   box_top;
        logic [POS_W-1:0]   box_left;
        logic [POS_W-1:0]   center_y;
        logic [POS_W-1:0]   center_x;
        logic               motion_found;
    } box_result_t;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             last;
    } mask_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_we = 1'b0;
    t_cfg_reg             cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     cfg_data = '0;

    logic                 s_valid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_data = '0;
    logic                 s_last = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_ready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;

    // mask pixel stream and frame results
    mask_item_t  pixel_queue[$];
    box_result_t frame_results[$];

    // configuration as the block should see it
    logic [SIZE_W-1:0] cfg_width, cfg_height, cfg_xe, cfg_ye;
    logic [POS_W-1:0]  cfg_xb, cfg_yb;
    logic [DEV_W-1:0]  cfg_dev;

    // frame accumulators
    logic [POS_W-1:0]   col_pos, row_pos, max_col, max_row;
    logic [SIZE_W-1:0]  min_col, min_row;
    logic [TALLY_W-1:0] tally;
    logic [VSUM_W-1:0]  vsum;
    logic [SSUM_W-1:0]  ssum;
    logic [CNT_W-1:0]   npix;

    int mismatches = 0;
    int results_seen = 0;
    int motion_frames = 0;
    int items_queued = 0;
    int frames_queued = 0;
    int phase_num = 0;
    int cycle_count = 0;
    bit steady_sender = 1'b0;
    bit long_hold_wanted = 1'b0;

    int         gap_left, burst_left;
    mask_item_t next_item;
    int         hold_left, held_phase;
    logic [15:0] stall_pattern;
    logic [5:0]  pattern_age;

    motion_mask_bounding_box uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),        // mask_pixel
        .s_axis_tlast  (s_last),        // frame_end
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        // motion_found, center_x, center_y, box_left, box_top, box_right, box_bottom,
        // changed_count
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    function automatic int effective_size(input logic [SIZE_W-1:0] v, input int limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return v;
    endfunction

    task automatic restart_frame();
        col_pos = '0;
        row_pos = '0;
        tally   = '0;
        min_col = SIZE_W'(effective_size(cfg_width, MAX_WIDTH));
        max_col = '0;
        min_row = SIZE_W'(effective_size(cfg_height, MAX_HEIGHT));
        max_row = '0;
        vsum    = '0;
        ssum    = '0;
        npix    = '0;
    endtask

    task automatic track_pixel(input logic [PIX_W-1:0] pix, input logic last);
        int w, h, col, row, xb, yb, l, t, r, b;
        longint unsigned n, d, vs, lhs, rhs;
        bit sampled;
        box_result_t res;
        w   = effective_size(cfg_width, MAX_WIDTH);
        h   = effective_size(cfg_height, MAX_HEIGHT);
        col = col_pos;
        row = row_pos;
        xb  = cfg_xb;
        yb  = cfg_yb;
        vsum = vsum + VSUM_W'(pix);
        ssum = ssum + SSUM_W'(pix) * SSUM_W'(pix);
        npix = npix + 1'b1;
        sampled = col >= xb && col < int'(cfg_xe) && row >= yb && row < int'(cfg_ye)
                  && ((col - xb) % 2 == 0) && ((row - yb) % 2 == 0)
                  && pix == CHANGE_VALUE;
        if (sampled) begin
            tally = tally + 1'b1;
            if (min_col > col) min_col = SIZE_W'(col);
            if (max_col < col) max_col = POS_W'(col);
            if (min_row > row) min_row = SIZE_W'(row);
            if (max_row < row) max_row = POS_W'(row);
        end
        if (!last) begin
            if (col + 1 >= w) begin
                col_pos = '0;
                row_pos = (row + 1 >= h) ? '0 : POS_W'(row + 1);
            end else begin
                col_pos = POS_W'(col + 1);
            end
        end else begin
            res = '0;
            n   = npix;
            d   = cfg_dev;
            vs  = vsum;
            lhs = n * ssum;
            rhs = vs * vs + d * d * n * n;
            if (lhs < rhs && tally != 0) begin
                l = min_col;
                t = min_row;
                r = max_col;
                b = max_row;
                if (l > BOX_PAD) l -= BOX_PAD;
                if (t > BOX_PAD) t -= BOX_PAD;
                if (r + BOX_PAD + 1 < w) r += BOX_PAD;
                if (b + BOX_PAD + 1 < h) b += BOX_PAD;
                res.motion_found  = 1'b1;
                res.center_x      = POS_W'(l + (r - l) / 2);
                res.center_y      = POS_W'(t + (b - t) / 2);
                res.box_left      = POS_W'(l);
                res.box_top       = POS_W'(t);
                res.box_right     = POS_W'(r);
                res.box_bottom    = POS_W'(b);
                res.changed_count = tally;
            end
            frame_results.insert(frame_results.size(), res);
            restart_frame();
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("frame result %0d: %s got %0d, expected %0d", results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic check_result(input logic [OUT_W-1:0] data);
        box_result_t got, want;
        got = data;
        results_seen++;
        if (frame_results.size() == 0) begin
            report_mismatch("unexpected result, motion_found", got.motion_found, 0);
        end else begin
            want = frame_results.pop_front();
            if (want.motion_found) motion_frames++;
            if (got.motion_found != want.motion_found)
                report_mismatch("motion_found", got.motion_found, want.motion_found);
            if (got.center_x != want.center_x)
                report_mismatch("center_x", got.center_x, want.center_x);
            if (got.center_y != want.center_y)
                report_mismatch("center_y", got.center_y, want.center_y);
            if (got.box_left != want.box_left)
                report_mismatch("box_left", got.box_left, want.box_left);
            if (got.box_top != want.box_top)
                report_mismatch("box_top", got.box_top, want.box_top);
            if (got.box_right != want.box_right)
                report_mismatch("box_right", got.box_right, want.box_right);
            if (got.box_bottom != want.box_bottom)
                report_mismatch("box_bottom", got.box_bottom, want.box_bottom);
            if (got.changed_count != want.changed_count)
                report_mismatch("changed_count", got.changed_count, want.changed_count);
        end
    endtask

    // pixel sender
    always @(posedge clk) begin
        if (!rst_n) begin
            s_valid    <= 1'b0;
            s_data     <= '0;
            s_last     <= 1'b0;
            gap_left   <= 0;
            burst_left <= 0;
        end else if (!s_valid || s_axis_tready) begin
            if (gap_left != 0) begin
                s_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pixel_queue.size() != 0) begin
                next_item = pixel_queue.pop_front();
                s_valid <= 1'b1;
                s_data  <= next_item.pix;
                s_last  <= next_item.last;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= steady_sender ? 0 : $urandom_range(0, 5);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(posedge clk) begin
        if (!rst_n) begin
            m_ready       <= 1'b0;
            hold_left     <= 0;
            held_phase    <= -1;
            stall_pattern <= 16'hFFFF;
            pattern_age   <= '0;
        end else begin
            pattern_age <= pattern_age + 1'b1;
            if (pattern_age == 6'd63)
                stall_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (long_hold_wanted && held_phase != phase_num && m_axis_tvalid) begin
                hold_left  <= LONG_HOLD;
                held_phase <= phase_num;
                m_ready    <= 1'b0;
            end else begin
                m_ready <= stall_pattern[pattern_age[3:0]];
            end
        end
    end

    // transfer monitor and checker
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_axis_tvalid && m_ready) check_result(m_axis_tdata);
            if (s_valid && s_axis_tready) track_pixel(s_data, s_last);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic wait_idle();
        do @(negedge clk);
        while (pixel_queue.size() != 0 || s_valid || frame_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input int value);
        logic [CFG_W-1:0] data;
        data = CFG_W'(value);
        // unused upper bits get random values
        case (idx)
            REG_WIN_X_BEGIN, REG_WIN_Y_BEGIN: data[10] = $urandom_range(0, 1);
            REG_MAX_DEVIATION: data[10:8] = $urandom_range(0, 7);
            default: ;
        endcase
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_FRAME_WIDTH:   cfg_width  = data;
            REG_FRAME_HEIGHT:  cfg_height = data;
            REG_WIN_X_BEGIN:   cfg_xb     = data[POS_W-1:0];
            REG_WIN_X_END:     cfg_xe     = data;
            REG_WIN_Y_BEGIN:   cfg_yb     = data[POS_W-1:0];
            REG_WIN_Y_END:     cfg_ye     = data;
            REG_MAX_DEVIATION: cfg_dev    = data[DEV_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int w, input int h, input int xb, input int xe,
                             input int yb, input int ye, input int dev);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_WIN_X_BEGIN, xb);
        write_reg(REG_WIN_X_END, xe);
        write_reg(REG_WIN_Y_BEGIN, yb);
        write_reg(REG_WIN_Y_END, ye);
        write_reg(REG_MAX_DEVIATION, dev);
        @(posedge clk);
        cfg_we <= 1'b0;
        phase_num++;
    endtask

    task automatic add_pixel(input int pix, input bit last);
        mask_item_t item;
        item.pix  = PIX_W'(pix);
        item.last = last;
        pixel_queue.insert(pixel_queue.size(), item);
        items_queued++;
        if (last) frames_queued++;
    endtask

    task automatic add_frame(input int len, input int density, input bit noisy);
        int pix;
        for (int i = 0; i < len; i++) begin
            if (noisy && $urandom_range(0, 3) == 0) pix = $urandom_range(0, 255);
            else pix = ($urandom_range(0, 99) < density) ? 255 : 0;
            add_pixel(pix, i == len - 1);
        end
    endtask

    initial begin
        int w, h, xb, xe, yb, ye, dev, len, round;
        cfg_width  = 640;
        cfg_height = 480;
        cfg_xb     = 0;
        cfg_xe     = 640;
        cfg_yb     = 0;
        cfg_ye     = 480;
        cfg_dev    = 100;
        restart_frame();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // 4x3 frame: changes at sampled and odd positions, a grey pixel, then tiny frames
        configure(4, 3, 0, 4, 0, 3, 255);
        add_pixel(255, 0); add_pixel(255, 0); add_pixel(0, 0);   add_pixel(0, 0);
        add_pixel(0, 0);   add_pixel(128, 0); add_pixel(0, 0);   add_pixel(0, 0);
        add_pixel(0, 0);   add_pixel(0, 0);   add_pixel(255, 0); add_pixel(0, 1);
        add_pixel(0, 1);
        add_pixel(255, 0); add_pixel(255, 0); add_pixel(255, 1);

        // zero width, oversize height, zero deviation bound
        configure(0, 2047, 0, 2047, 0, 2047, 0);
        add_pixel(255, 0); add_pixel(255, 0); add_pixel(255, 0); add_pixel(255, 1);

        round = 0;
        while (items_queued < 650 || frames_queued < 30) begin
            steady_sender    = ($urandom_range(0, 3) == 0);
            long_hold_wanted = 1'b0;
            if (round == 0) begin
                // oversize width: window starts mid-row, a change at an odd offset
                configure(2047, 2, 20, 2047, 0, 2047, 200);
                for (int i = 0; i < 40; i++)
                    add_pixel((i == 20 || i == 23 || i == 24) ? 255 : 0, i == 39);
            end else if (round == 2) begin
                configure(2, 2, 0, 2, 0, 2, 255);
                long_hold_wanted = 1'b1;
                steady_sender    = 1'b1;
                repeat (12) add_frame(4, 60, 0);
            end else if (round == 4) begin
                configure(2047, 2047, 0, 1024, 0, 1024, $urandom_range(60, 255));
                repeat (3) add_frame($urandom_range(5, 60), $urandom_range(0, 100), 1);
            end else begin
                w = $urandom_range(1, 20);
                h = $urandom_range(1, 4);
                if ($urandom_range(0, 3) != 0) begin
                    xb = $urandom_range(0, w / 2);
                    xe = $urandom_range(xb + 1, w + 2);
                    yb = $urandom_range(0, h / 2);
                    ye = $urandom_range(yb + 1, h + 1);
                end else begin
                    xb = $urandom_range(0, w);
                    xe = $urandom_range(0, w + 2);
                    yb = $urandom_range(0, h);
                    ye = $urandom_range(0, h + 1);
                end
                case ($urandom_range(0, 5))
                    0: dev = 0;
                    1: dev = 255;
                    2: dev = $urandom_range(1, 254);
                    default: dev = $urandom_range(70, 130);
                endcase
                configure(w, h, xb, xe, yb, ye, dev);
                repeat ($urandom_range(3, 6)) begin
                    len = ($urandom_range(0, 3) != 0) ? w * h
                                                      : $urandom_range(1, 2 * w * h + 3);
                    add_frame(len, $urandom_range(0, 100), $urandom_range(0, 3) == 0);
                end
            end
            round++;
        end

        wait_idle();
        $display("ran %0d configurations, %0d mask pixels, %0d frame results checked",
                 phase_num, items_queued, results_seen);
        $display("%0d frames reported motion, %0d reported none",
                 motion_frames, results_seen - motion_frames);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
